// ===== design/itoa_pkg.sv =====
package itoa_pkg;

  localparam int MAX_CHARS  = 64;
  localparam int VALUE_BITS = 64;

  // divider: quotient bits resolved per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int WORK_W    = DIV_STEPS * DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam int DIG_AW = $clog2(VALUE_BITS);
  localparam int NDIG_W = $clog2(VALUE_BITS + 1);
  localparam int LEN_W  = 8;

  localparam int FL_ZERO   = 0;
  localparam int FL_PLUS   = 1;
  localparam int FL_SPACE  = 2;
  localparam int FL_LEFT   = 3;
  localparam int FL_PREFIX = 4;
  localparam int FL_SIGNED = 5;
  localparam int FL_CAPS   = 6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADBASE = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] RADIX_BIN = 6'd2;
  localparam logic [5:0] RADIX_OCT = 6'd8;
  localparam logic [5:0] RADIX_HEX = 6'd16;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {SG_NONE, SG_MINUS, SG_PLUS, SG_SPACE} sign_e;

  typedef struct packed {
    logic                  bad;
    logic [VALUE_BITS-1:0] mag;
    logic [5:0]            radix;
    logic [5:0]            fw;
    logic [5:0]            md;
    sign_e                 sign;
    logic [1:0]            plen;
    logic                  zero;
    logic                  left;
    logic                  caps;
  } item_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
    logic [1:0] status;
  } beat_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic caps);
    logic [7:0] base;
    base = caps ? CH_UA : CH_LA;
    if (d < 6'd10) return CH_ZERO + {2'b00, d};
    return base + {2'b00, d} - 8'd10;
  endfunction

  function automatic logic [7:0] sign_char(input sign_e s);
    case (s)
      SG_MINUS: return CH_MINUS;
      SG_PLUS:  return CH_PLUS;
      default:  return CH_SPACE;
    endcase
  endfunction

endpackage

// ===== design/integer_to_ascii_formatter_unit.sv =====
// Channel | Handshake            | Beat
// input   | push_i / full_o      | value_i, radix_i, field_width_i, min_digits_i, flags_i
// result  | empty_o / pop_i      | character_o, last_o, status_o
//
// Per item: a hand-over, then each digit in the shared divider (8 quotient bits a
// cycle), then sizing, then one beat a cycle while the result queue has room.
// Reset is asynchronous, active low, and clears all queues at once.
// A two-deep queue after the front takes items while the back works; the four-deep
// result queue rides out short pop stalls, longer ones hold the back mid-emission.
module integer_to_ascii_formatter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [63:0] value_i,
  input  logic [5:0]  radix_i,
  input  logic [5:0]  field_width_i,
  input  logic [5:0]  min_digits_i,
  input  logic [6:0]  flags_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  character_o,
  output logic        last_o,
  output logic [1:0]  status_o
);
  import itoa_pkg::*;

  item_t item;
  logic  item_valid, item_ready;

  // front: classify sign, prefix and magnitude, hold in a short queue
  itoa_front u_front (
    .clk_i, .rst_ni, .value_i, .radix_i, .field_width_i, .min_digits_i,
    .flags_i, .push_i, .full_o,
    .item_o(item), .item_valid_o(item_valid), .item_ready_i(item_ready)
  );

  // back: digit extraction, layout and character emission
  itoa_back u_back (
    .clk_i, .rst_ni,
    .item_i(item), .item_valid_i(item_valid), .item_ready_o(item_ready),
    .character_o, .last_o, .status_o, .empty_o, .pop_i
  );

  // a bad-base result is a lone NUL beat
  a_badbase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o == ST_BADBASE) |-> (last_o && character_o == CH_NUL))
    else $error("bad-base beat malformed");

  // text never carries NUL
  a_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && character_o == CH_NUL) |-> (status_o == ST_BADBASE))
    else $error("NUL character in text");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (status_o == ST_OK || status_o == ST_BADBASE || status_o == ST_TRUNC))
    else $error("status code out of range");

  // once the back takes an item it is busy and drops ready
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && item_ready) |=> !item_ready)
    else $error("back took item while busy");

endmodule

// ===== design/itoa_front.sv =====
module itoa_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [63:0]           value_i,
  input  logic [5:0]            radix_i,
  input  logic [5:0]            field_width_i,
  input  logic [5:0]            min_digits_i,
  input  logic [6:0]            flags_i,
  input  logic                  push_i,
  output logic                  full_o,
  output itoa_pkg::item_t       item_o,
  output logic                  item_valid_o,
  input  logic                  item_ready_i
);
  import itoa_pkg::*;

  logic [VALUE_BITS-1:0] v;
  logic                  neg;
  item_t                 cls;
  item_t                 q_q [2];
  logic                  wr_q, rd_q;
  logic [1:0]            cnt_q;
  logic                  do_push, do_pop;

  // classify the incoming item
  always_comb begin
    v         = value_i[VALUE_BITS-1:0];
    neg       = flags_i[FL_SIGNED] & v[VALUE_BITS-1];
    cls.bad   = (radix_i < RADIX_MIN) || (radix_i > RADIX_MAX);
    cls.mag   = neg ? (~v + 1'b1) : v;
    cls.radix = radix_i;
    cls.fw    = field_width_i;
    cls.md    = min_digits_i;
    cls.left  = flags_i[FL_LEFT];
    cls.zero  = flags_i[FL_ZERO] & ~flags_i[FL_LEFT];
    cls.caps  = flags_i[FL_CAPS];
    if (neg) cls.sign = SG_MINUS;
    else if (flags_i[FL_SIGNED] && flags_i[FL_PLUS]) cls.sign = SG_PLUS;
    else if (flags_i[FL_SIGNED] && flags_i[FL_SPACE]) cls.sign = SG_SPACE;
    else cls.sign = SG_NONE;
    if (!flags_i[FL_PREFIX]) cls.plen = 2'd0;
    else if (radix_i == RADIX_BIN || radix_i == RADIX_HEX) cls.plen = 2'd2;
    else if (radix_i == RADIX_OCT) cls.plen = 2'd1;
    else cls.plen = 2'd0;
  end

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_q[rd_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = item_valid_o & item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) q_q[wr_q] <= cls;
  end

endmodule

// ===== design/itoa_back.sv =====
module itoa_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  itoa_pkg::item_t item_i,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  output logic [7:0]      character_o,
  output logic            last_o,
  output logic [1:0]      status_o,
  output logic            empty_o,
  input  logic            pop_i
);
  import itoa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SIZE, S_EMIT} state_e;

  state_e              state_q;
  item_t               it_q;
  logic [WORK_W-1:0]   work_q, work_d;
  logic [5:0]          rem_q, rem_d;
  logic [STEP_W-1:0]   step_q;
  logic [NDIG_W-1:0]   ndig_q;
  logic [5:0]          dig_mem [VALUE_BITS];
  logic [5:0]          rdata_q;

  logic [LEN_W-1:0]    s0_q, p0_q, z0_q, d0_q, e0_q, emit_q, k_q;
  logic                trunc_q;
  logic [LEN_W-1:0]    s0_d, p0_d, z0_d, d0_d, e0_d, emit_d;
  logic                trunc_d;

  logic                s1_valid_q, s1_dig_q, s1_caps_q;
  beat_t               s1_q, s1_d;
  logic                s1_dig_d;

  beat_t               oq_q [4];
  logic [1:0]          owr_q, ord_q;
  logic [2:0]          ocnt_q;
  beat_t               obeat;
  logic                issue, do_pop, last_step;
  logic [DIG_AW-1:0]   rd_addr;

  // eight restoring-division steps per cycle; quotient bits shift in below
  always_comb begin
    logic [6:0] t;
    rem_d  = rem_q;
    work_d = work_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      t      = {rem_d, work_d[WORK_W-1]};
      work_d = {work_d[WORK_W-2:0], 1'b0};
      if (t >= {1'b0, it_q.radix}) begin
        t         = t - {1'b0, it_q.radix};
        work_d[0] = 1'b1;
      end
      rem_d = t[5:0];
    end
  end

  assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));

  // run layout from digit count
  always_comb begin
    logic [LEN_W-1:0] nd, cnt, used, pad, n, sgn;
    nd      = LEN_W'(ndig_q);
    cnt     = (nd > {2'b00, it_q.md}) ? nd : {2'b00, it_q.md};
    sgn     = (it_q.sign != SG_NONE) ? 8'd1 : 8'd0;
    used    = sgn + {6'd0, it_q.plen} + cnt;
    pad     = ({2'b00, it_q.fw} > used) ? ({2'b00, it_q.fw} - used) : 8'd0;
    n       = used + pad;
    s0_d    = (it_q.zero || it_q.left) ? 8'd0 : pad;
    p0_d    = s0_d + sgn;
    z0_d    = p0_d + {6'd0, it_q.plen};
    d0_d    = z0_d + (it_q.zero ? pad : 8'd0) + (cnt - nd);
    e0_d    = d0_d + nd;
    trunc_d = n > LEN_W'(MAX_CHARS);
    emit_d  = trunc_d ? LEN_W'(MAX_CHARS) : n;
    if (it_q.bad) begin
      trunc_d = 1'b0;
      emit_d  = 8'd1;
    end
  end

  assign issue   = (state_q == S_EMIT) && (k_q < emit_q) &&
                   ((ocnt_q + {2'b00, s1_valid_q}) <= 3'd3);
  assign rd_addr = DIG_AW'(e0_q - 8'd1 - k_q);

  always_comb begin
    s1_dig_d     = 1'b0;
    s1_d.last    = (k_q == emit_q - 8'd1);
    s1_d.status  = trunc_q ? ST_TRUNC : ST_OK;
    if (it_q.bad) begin
      s1_d.chr    = CH_NUL;
      s1_d.status = ST_BADBASE;
    end else if (k_q < s0_q) begin
      s1_d.chr = CH_SPACE;
    end else if (k_q < p0_q) begin
      s1_d.chr = sign_char(it_q.sign);
    end else if (k_q < z0_q) begin
      if (k_q == p0_q) s1_d.chr = CH_ZERO;
      else s1_d.chr = (it_q.radix == RADIX_BIN) ? CH_B : CH_X;
    end else if (k_q < d0_q) begin
      s1_d.chr = CH_ZERO;
    end else if (k_q < e0_q) begin
      s1_d.chr = CH_ZERO;
      s1_dig_d = 1'b1;
    end else begin
      s1_d.chr = CH_SPACE;
    end
  end

  always_comb begin
    obeat     = s1_q;
    if (s1_dig_q) obeat.chr = digit_char(rdata_q, s1_caps_q);
  end

  assign item_ready_o = (state_q == S_IDLE);
  assign empty_o      = (ocnt_q == 3'd0);
  assign do_pop       = pop_i & ~empty_o;
  assign character_o  = oq_q[ord_q].chr;
  assign last_o       = oq_q[ord_q].last;
  assign status_o     = oq_q[ord_q].status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= '0;
      ndig_q     <= '0;
      k_q        <= '0;
      s1_valid_q <= 1'b0;
      owr_q      <= 2'd0;
      ord_q      <= 2'd0;
      ocnt_q     <= 3'd0;
    end else begin
      s1_valid_q <= issue;
      if (s1_valid_q) owr_q <= owr_q + 2'd1;
      if (do_pop) ord_q <= ord_q + 2'd1;
      ocnt_q <= ocnt_q + {2'b00, s1_valid_q} - {2'b00, do_pop};
      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            step_q  <= '0;
            ndig_q  <= '0;
            state_q <= item_i.bad ? S_SIZE : S_DIV;
          end
        end
        S_DIV: begin
          if (last_step) begin
            step_q <= '0;
            ndig_q <= ndig_q + 1'b1;
            if (work_d == '0 || ndig_q == NDIG_W'(VALUE_BITS - 1)) state_q <= S_SIZE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_SIZE: begin
          k_q     <= '0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (issue) begin
            k_q <= k_q + 8'd1;
            if (k_q == emit_q - 8'd1) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && item_valid_i) begin
      it_q   <= item_i;
      work_q <= WORK_W'(item_i.mag);
      rem_q  <= '0;
    end else if (state_q == S_DIV) begin
      work_q <= work_d;
      rem_q  <= last_step ? 6'd0 : rem_d;
    end
    if (state_q == S_SIZE) begin
      s0_q    <= s0_d;
      p0_q    <= p0_d;
      z0_q    <= z0_d;
      d0_q    <= d0_d;
      e0_q    <= e0_d;
      emit_q  <= emit_d;
      trunc_q <= trunc_d;
    end
    if (issue) begin
      s1_q      <= s1_d;
      s1_dig_q  <= s1_dig_d;
      s1_caps_q <= it_q.caps;
    end
    if (s1_valid_q) oq_q[owr_q] <= obeat;
  end

  // digit store, written LSB digit first
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV && last_step) dig_mem[ndig_q[DIG_AW-1:0]] <= rem_d;
    rdata_q <= dig_mem[rd_addr];
  end

endmodule

// ===== tb/itoa_text_checker.sv =====
`timescale 1ns / 100ps

module itoa_text_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_o,
  input  logic [63:0] value_i,
  input  logic [5:0]  radix_i,
  input  logic [5:0]  field_width_i,
  input  logic [5:0]  min_digits_i,
  input  logic [6:0]  flags_i,
  input  logic        empty_o,
  input  logic        pop_i,
  input  logic [7:0]  character_o,
  input  logic        last_o,
  input  logic [1:0]  status_o,
  output int          errors_o,
  output int          pending_o
);
  import itoa_pkg::*;

  beat_t text_q[$];

  task automatic format_item(input logic [63:0] val, input logic [5:0] radix,
                             input logic [5:0] fw, input logic [5:0] md,
                             input logic [6:0] fl);
    logic [7:0]  line[$];
    logic [7:0]  digs[$];
    logic [63:0] mag;
    logic [7:0]  sgn;
    logic [7:0]  letter;
    int          plen, cnt, used, pad, emit;
    beat_t       b;
    mag  = val;
    sgn  = CH_NUL;
    plen = 0;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      b.chr = CH_NUL; b.last = 1'b1; b.status = ST_BADBASE;
      text_q.push_back(b);
      return;
    end
    if (fl[FL_LEFT]) fl[FL_ZERO] = 1'b0;
    if (fl[FL_SIGNED]) begin
      if (mag[63]) begin
        sgn = CH_MINUS;
        mag = -mag;
      end else if (fl[FL_PLUS]) begin
        sgn = CH_PLUS;
      end else if (fl[FL_SPACE]) begin
        sgn = CH_SPACE;
      end
    end
    if (fl[FL_PREFIX]) begin
      if (radix == RADIX_BIN || radix == RADIX_HEX) plen = 2;
      else if (radix == RADIX_OCT) plen = 1;
    end
    // digits computed least significant first, pushed to the front so they read most significant first
    if (mag == 0) digs.push_front(CH_ZERO);
    while (mag != 0) begin
      letter = 8'(mag % radix);
      if (letter < 10) letter = CH_ZERO + letter;
      else letter = (fl[FL_CAPS] ? CH_UA : CH_LA) + letter - 8'd10;
      digs.push_front(letter);
      mag = mag / radix;
    end
    cnt  = (digs.size() > md) ? digs.size() : md;
    used = (sgn != CH_NUL) + plen + cnt;
    pad  = (fw > used) ? fw - used : 0;
    if (!fl[FL_ZERO] && !fl[FL_LEFT]) repeat (pad) line.push_back(CH_SPACE);
    if (sgn != CH_NUL) line.push_back(sgn);
    if (plen > 0) line.push_back(CH_ZERO);
    if (plen == 2) line.push_back(radix == RADIX_BIN ? CH_B : CH_X);
    if (fl[FL_ZERO]) repeat (pad) line.push_back(CH_ZERO);
    repeat (cnt - digs.size()) line.push_back(CH_ZERO);
    foreach (digs[i]) line.push_back(digs[i]);
    if (fl[FL_LEFT]) repeat (pad) line.push_back(CH_SPACE);
    emit = (line.size() > MAX_CHARS) ? MAX_CHARS : line.size();
    for (int k = 0; k < emit; k++) begin
      b.chr    = line[k];
      b.last   = (k == emit - 1);
      b.status = (line.size() > MAX_CHARS) ? ST_TRUNC : ST_OK;
      text_q.push_back(b);
    end
  endtask

  assign pending_o = text_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t want;
    int    bad;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      bad = 0;
      if (push_i && !full_o)
        format_item(value_i, radix_i, field_width_i, min_digits_i, flags_i);
      if (pop_i && !empty_o) begin
        if (text_q.size() == 0) begin
          $error("result beat with nothing expected");
          bad++;
        end else begin
          want = text_q.pop_front();
          if (want.chr !== character_o) begin
            $error("character: expected %h, got %h", want.chr, character_o);
            bad++;
          end
          if (want.last !== last_o) begin
            $error("last: expected %b, got %b", want.last, last_o);
            bad++;
          end
          if (want.status !== status_o) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            bad++;
          end
        end
      end
      errors_o <= errors_o + bad;
    end
  end

endmodule

// ===== tb/integer_to_ascii_formatter_unit_tb.sv =====
`timescale 1ns / 100ps

module integer_to_ascii_formatter_unit_tb;
  import itoa_pkg::*;

  localparam int LIMIT = 1000000;

  logic        clk, rst_n;
  logic        push, full, empty, pop, last;
  logic [63:0] value;
  logic [5:0]  radix, fw, md;
  logic [6:0]  flags;
  logic [7:0]  character;
  logic [1:0]  status;
  int          errors, pending;
  int          cycles;

  integer_to_ascii_formatter_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_o(full),
    .value_i(value), .radix_i(radix), .field_width_i(fw),
    .min_digits_i(md), .flags_i(flags), .empty_o(empty), .pop_i(pop),
    .character_o(character), .last_o(last), .status_o(status)
  );

  itoa_text_checker i_chk (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_o(full),
    .value_i(value), .radix_i(radix), .field_width_i(fw),
    .min_digits_i(md), .flags_i(flags), .empty_o(empty), .pop_i(pop),
    .character_o(character), .last_o(last), .status_o(status),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: slowest run is ~180 items, each a full-length conversion plus pop stalls and gaps.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: long free-running stretches, then phases of random stalls.
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if ((cycles / 500) % 3 == 0) pop <= 1'b1;
      else pop <= ($urandom_range(0, 3) != 0);
    end
  end

  // Holds one beat until accepted; the next beat follows at the same edge.
  task automatic send_beat(input logic [63:0] v, input logic [5:0] r,
                           input logic [5:0] w, input logic [5:0] d,
                           input logic [6:0] f);
    push  <= 1'b1;
    value <= v;
    radix <= r;
    fw    <= w;
    md    <= d;
    flags <= f;
    do @(posedge clk); while (full);
  endtask

  // Random value: mostly small or edge numbers so digit runs vary in length.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 64'($urandom_range(0, 20));
      1:       return {$urandom(), $urandom()};
      2:       return 64'h8000_0000_0000_0000 ^ 64'($urandom_range(0, 3));
      3:       return -64'($urandom_range(1, 1000));
      4:       return {32'd0, $urandom()};
      default: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [5:0] pick_radix();
    case ($urandom_range(0, 9))
      0:       return 6'($urandom_range(0, 63));  // may be out of range
      1:       return RADIX_BIN;
      2:       return RADIX_OCT;
      3:       return RADIX_HEX;
      4:       return 6'd10;
      default: return 6'($urandom_range(RADIX_MIN, RADIX_MAX));
    endcase
  endfunction

  initial begin
    int burst;
    int gap;
    rst_n = 1'b0;
    push  = 1'b0;
    value = '0;
    radix = RADIX_MIN;
    fw    = '0;
    md    = '0;
    flags = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, each flag, bad bases, zero, most negative, overflow
    send_beat(64'd0, 6'd10, 6'd0, 6'd0, 7'h00);
    send_beat(64'd0, RADIX_HEX, 6'd0, 6'd0, 7'h10);
    send_beat(64'd0, RADIX_OCT, 6'd5, 6'd3, 7'h11);
    send_beat(64'd42, 6'd0, 6'd0, 6'd0, 7'h00);
    send_beat(64'd42, 6'd1, 6'd0, 6'd0, 7'h00);
    send_beat(64'd42, 6'd37, 6'd0, 6'd0, 7'h00);
    send_beat(64'd42, 6'd63, 6'd63, 6'd63, 7'h7F);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, RADIX_BIN, 6'd0, 6'd0, 7'h00);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, RADIX_BIN, 6'd0, 6'd0, 7'h10);
    send_beat(64'h8000_0000_0000_0000, 6'd10, 6'd0, 6'd0, 7'h20);
    send_beat(64'h8000_0000_0000_0000, RADIX_BIN, 6'd0, 6'd0, 7'h30);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 6'd10, 6'd0, 6'd0, 7'h00);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 6'd10, 6'd8, 6'd0, 7'h20);
    send_beat(64'd123, 6'd10, 6'd10, 6'd0, 7'h22);
    send_beat(64'd123, 6'd10, 6'd10, 6'd0, 7'h24);
    send_beat(64'd123, 6'd10, 6'd10, 6'd0, 7'h06);
    send_beat(64'd123, 6'd10, 6'd10, 6'd0, 7'h28);
    send_beat(64'd123, 6'd10, 6'd10, 6'd0, 7'h09);
    send_beat(64'd123, 6'd10, 6'd12, 6'd6, 7'h23);
    send_beat(64'hDEAD_BEEF, RADIX_HEX, 6'd20, 6'd0, 7'h51);
    send_beat(64'hDEAD_BEEF, 6'd36, 6'd63, 6'd63, 7'h40);
    send_beat(64'd35, 6'd36, 6'd0, 6'd0, 7'h00);
    send_beat(64'd7, RADIX_BIN, 6'd63, 6'd0, 7'h00);
    send_beat(64'd7, RADIX_BIN, 6'd0, 6'd63, 7'h13);

    for (int n = 0; n < 156; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap   = $urandom_range(0, 60);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      send_beat(pick_value(), pick_radix(),
                ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 12)),
                ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 6)),
                7'($urandom_range(0, 127)));
    end
    push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
